>>> sv/assert_macros.svh
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/prbpp_pkg.sv
// package with command, status, mode and register index codes for the raw pixel store
package prbpp_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_PATCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;
  localparam logic [1:0] MODE_INTERP = 2'd1;
  localparam logic [1:0] MODE_ZERO   = 2'd2;
  localparam logic [2:0] REG_ROW_BYTES  = 3'd0;
  localparam logic [2:0] REG_ROW_PIXELS = 3'd1;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd2;
  localparam logic [2:0] REG_MODE       = 3'd3;
  localparam logic [2:0] REG_DNG        = 3'd4;
endpackage

>>> sv/packed_raw_pixel_store_bad_pixel_patch_unit.sv
// top level: packed raw pixel store with bad pixel patching
//
// s_axis carries one command transaction: tdata = {value, y, x, command}
// from the lowest bit up (command 2, x 14, y 14, value 14 bits, padded to 48).
// m_axis returns one result per command: tdata = {status, pixel_value}
// (pixel_value 14, status 2 bits, padded to 16).
// cfg_valid/cfg_ready with cfg_index/cfg_data write the control registers
// (row bytes, row pixels, row count, removal mode, dng saving); the user must
// write them only while idle, as the block itself does not enforce it.
// the frame lives in a single-port byte memory with a registered read; a sequencer
// walks it one byte at a time (S_NEXT then S_DIV per byte). a pixel spans up to
// three bytes. a patch reads up to four neighbors, divides by shift or reciprocal
// multiply, then writes back; an unknown command returns a status only.
// the next command can be accepted in the cycle after the result register loads,
// so one command is in work at a time.
// the result sits in an output register: the next command is accepted as soon
// as the sequencer finishes, while that result still waits for m_axis_tready;
// a stalled receiver holds the sequencer once it has a second result ready.
// reset clears control registers and state; memory contents are undefined
// until written and no clearing pass runs.
module packed_raw_pixel_store_bad_pixel_patch_unit
  import prbpp_pkg::*;
#(
  parameter int PIXEL_BITS  = 12,
  parameter int FRAME_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // command, x, y, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pixel_value, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  `include "assert_macros.svh"

  localparam int GP = (PIXEL_BITS % 2 == 1) ? 16 : ((PIXEL_BITS % 4 == 2) ? 8 :
                      ((PIXEL_BITS % 8 == 4) ? 4 : 2));
  localparam int GB = GP * PIXEL_BITS / 8;
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int BW = 40;
  localparam int GW = $clog2(GP);
  localparam int PW = $clog2(GP * PIXEL_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADDR  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RWAIT = 4'd3;
  localparam logic [3:0] S_NEXT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WWAIT = 4'd7;
  localparam logic [3:0] S_WWR   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_ADDM  = 4'd10;

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rdata;
  logic [AW-1:0] maddr;
  logic          mwe;
  logic [7:0]    mwdata;

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    rdata <= mem[maddr];
  end

  logic [14:0] row_bytes;
  logic [13:0] row_pixels, row_count;
  logic [1:0]  removal_mode;
  logic        dng_saving;

  logic [3:0]  state;
  logic [1:0]  cmd;
  logic [13:0] px, py, pval;
  logic [2:0]  k;           // neighbor index, 4 = target
  logic [13:0] cx, cy;
  logic [BW-1:0] prod, base;
  logic [1:0]  bi;          // byte index within pixel span
  logic [23:0] acc;         // up to three bytes of stream
  logic [15:0] sum;
  logic [2:0]  cnt;
  logic        bad;
  logic [13:0] res;
  logic [1:0]  rstat;
  logic        rpend;
  logic [13:0] o_res;
  logic [1:0]  o_stat;
  logic        load_out;
  logic [15:0] quo;
  logic [1:0]  dstep;

  logic [GW-1:0] slot;
  logic [PW-1:0] pos0;
  logic [PW-1:0] posb;
  logic [BW-1:0] baddr;
  logic [4:0]    lead;      // bit offset of pixel in first byte
  logic [PIXEL_BITS-1:0] got;
  logic [23:0]   pmask, pnew;
  logic [7:0]    wbyte;
  logic          inb;

  assign slot = cx[GW-1:0];
  assign pos0 = PW'(slot * PIXEL_BITS);
  assign lead = 5'(pos0[2:0]);
  assign posb = PW'({pos0[PW-1:3], 3'b000} + 8 * bi);
  assign baddr = base + BW'(posb[PW-1:3] ^ 1'b1);
  assign inb = (base + BW'(GB)) <= BW'(FRAME_BYTES);
  assign got = PIXEL_BITS'(acc >> (24 - lead - PIXEL_BITS));
  assign pmask = 24'(((1 << PIXEL_BITS) - 1)) << (24 - lead - PIXEL_BITS);
  assign pnew = 24'(res[PIXEL_BITS-1:0]) << (24 - lead - PIXEL_BITS);
  always_comb begin
    unique case (bi)
      2'd0: wbyte = (rdata & ~pmask[23:16]) | (pnew[23:16] & pmask[23:16]);
      2'd1: wbyte = (rdata & ~pmask[15:8]) | (pnew[15:8] & pmask[15:8]);
      default: wbyte = (rdata & ~pmask[7:0]) | (pnew[7:0] & pmask[7:0]);
    endcase
  end
  logic [1:0] nbytes;
  assign nbytes = 2'((lead + PIXEL_BITS + 7) / 8 - 1);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {o_stat, o_res};
  assign m_axis_tvalid = rpend;
  assign load_out = (state == S_DONE) && (!rpend || m_axis_tready);

  always_comb begin
    mwe = (state == S_WWR);
    mwdata = wbyte;
    maddr = AW'(baddr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= '0; row_pixels <= '0; row_count <= '0;
      removal_mode <= '0; dng_saving <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_BYTES:  row_bytes <= cfg_data[14:0];
        REG_ROW_PIXELS: row_pixels <= cfg_data[13:0];
        REG_ROW_COUNT:  row_count <= cfg_data[13:0];
        REG_MODE:       removal_mode <= cfg_data[1:0];
        REG_DNG:        dng_saving <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpend <= 1'b0;
      o_res <= '0; o_stat <= ST_DONE;
    end else if (load_out) begin
      rpend <= 1'b1;
      o_res <= res; o_stat <= rstat;
    end else if (m_axis_tready) begin
      rpend <= 1'b0;
    end
  end

  logic in_border, interp;
  assign in_border = px >= 14'd2 && 15'(px) + 15'd2 < 15'(row_pixels) &&
                     py >= 14'd2 && 15'(py) + 15'd2 < 15'(row_count);
  assign interp = removal_mode == MODE_INTERP || dng_saving;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res <= '0; rstat <= ST_DONE;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tdata[1:0];
          px <= s_axis_tdata[15:2];
          py <= s_axis_tdata[29:16];
          pval <= s_axis_tdata[43:30];
          sum <= '0; cnt <= '0; bad <= 1'b0;
          state <= S_ADDR;
          if (s_axis_tdata[1:0] == CMD_PATCH) k <= 3'd0;
          else k <= 3'd4;
        end
        S_ADDR: begin
          if (k == 3'd4) begin
            cx <= px; cy <= py;
            if (cmd == CMD_PATCH && !(in_border && (interp || removal_mode == MODE_ZERO)))
              begin res <= '0; rstat <= ST_SKIP; state <= S_DONE; end
            else if (cmd != CMD_PATCH && cmd != CMD_WRITE && cmd != CMD_READ)
              begin res <= '0; rstat <= ST_SKIP; state <= S_DONE; end
            else if (cmd == CMD_PATCH && interp && bad)
              begin res <= '0; rstat <= ST_RANGE; state <= S_DONE; end
            else if (cmd == CMD_PATCH && interp && cnt == 3'd0)
              begin res <= '0; rstat <= ST_SKIP; state <= S_DONE; end
            else state <= S_ADDM;
          end else begin
            if (!(in_border && interp)) k <= 3'd4;
            else begin
              cx <= k[0] ? px + 14'd2 : px - 14'd2;
              cy <= k[1] ? py + 14'd2 : py - 14'd2;
              state <= S_ADDM;
            end
          end
        end
        S_ADDM: begin
          prod <= BW'(cy) * BW'(row_bytes);
          state <= S_RD;
          bi <= 2'd0;
        end
        S_RD: begin
          base <= prod + BW'(cx >> GW) * BW'(GB);
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (!inb) begin
            if (k == 3'd4) begin res <= '0; rstat <= ST_RANGE; state <= S_DONE; end
            else begin bad <= 1'b1; k <= k + 3'd1; state <= S_ADDR; end
          end else if (k == 3'd4 && cmd == CMD_PATCH) begin
            if (interp) res <= 14'(quo);
            else res <= '0;
            rstat <= ST_DONE; bi <= 2'd0; state <= S_WRD;
          end else if (k == 3'd4 && cmd == CMD_WRITE) begin
            res <= 14'(pval[PIXEL_BITS-1:0]); rstat <= ST_DONE;
            bi <= 2'd0; state <= S_WRD;
          end else state <= S_NEXT;
        end
        S_NEXT: begin
          // address presented this cycle, data next
          state <= S_DIV;
        end
        S_DIV: begin
          acc <= {acc[15:0], rdata};
          if (bi == nbytes) begin
            bi <= 2'd0;
            dstep <= 2'd0;
            state <= S_WWAIT;
          end else begin
            bi <= bi + 2'd1;
            state <= S_NEXT;
          end
        end
        S_WWAIT: begin
          if (dstep == 2'd0) begin
            acc <= acc << (8 * (2 - nbytes));
            dstep <= 2'd1;
          end else if (k == 3'd4) begin
            res <= 14'(got); rstat <= ST_DONE; state <= S_DONE;
          end else begin
            if (got != '0) begin sum <= sum + 16'(got); cnt <= cnt + 3'd1; end
            k <= k + 3'd1;
            state <= (k == 3'd3) ? S_WRD : S_ADDR;
            if (k == 3'd3) begin quo <= '0; dstep <= 2'd0; bi <= 2'd3; end
          end
        end
        S_WRD: begin
          if (bi == 2'd3) begin
            // divide sum by count (1..4): shifts, or a reciprocal multiply for three
            case (cnt)
              3'd1: quo <= sum;
              3'd2: quo <= sum >> 1;
              3'd3: quo <= 16'((32'(sum) * 32'd43691) >> 17);
              default: quo <= sum >> 2;
            endcase
            k <= 3'd4; state <= S_ADDR;
          end else state <= S_WWR;
        end
        S_WWR: begin
          if (bi == nbytes) begin
            if (cmd == CMD_WRITE) res <= '0;
            state <= S_DONE;
          end else begin
            bi <= bi + 2'd1;
            state <= S_WRD;
          end
        end
        S_DONE: if (load_out) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_no_write_idle, state == S_IDLE, !mwe)
  `ASSERT_IMP(a_status_zero_pix, rpend && o_stat != ST_DONE, o_res == '0)
  `ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state == S_ADDR)
endmodule

>>> tb/packed_raw_pixel_store_bad_pixel_patch_unit_tb.sv
// testbench for the packed raw pixel store with bad pixel patching
module packed_raw_pixel_store_bad_pixel_patch_unit_tb;
  import prbpp_pkg::*;

  localparam int PB = 12;
  localparam int GP = 4;
  localparam int GB = 6;
  localparam int FB = 262144;
  localparam int PMASK = (1 << PB) - 1;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [1:0]  cmd;
    int          x;
    int          y;
    logic [13:0] value;
  } pixel_cmd_t;

  typedef struct {
    logic [13:0] pix;
    logic [1:0]  st;
  } pixel_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  packed_raw_pixel_store_bad_pixel_patch_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the frame store: byte data and per-bit written flags
  bit [7:0] frame_bytes[int];
  bit [7:0] frame_written[int];
  int cfg_rb, cfg_rp, cfg_rc, cfg_mode, cfg_dng;

  pixel_result_t results_due[$];
  int  errors;
  int  cycles;
  int  stall_left;
  bit  quiet;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint group_addr(int x, int y);
    return longint'(y) * cfg_rb + longint'(x / GP) * GB;
  endfunction

  function automatic bit pixel_known(longint base, int slot);
    int pos;
    int idx;
    for (int b = 0; b < PB; b++) begin
      pos = slot * PB + b;
      idx = int'(base) + ((pos >> 3) ^ 1);
      if (!frame_written.exists(idx)) return 0;
      if (!frame_written[idx][7 - (pos & 7)]) return 0;
    end
    return 1;
  endfunction

  function automatic int pixel_load(longint base, int slot);
    int v;
    int pos;
    int idx;
    v = 0;
    for (int b = 0; b < PB; b++) begin
      pos = slot * PB + b;
      idx = int'(base) + ((pos >> 3) ^ 1);
      v = (v << 1) | (frame_bytes.exists(idx) ? frame_bytes[idx][7 - (pos & 7)] : 1'b0);
    end
    return v;
  endfunction

  function automatic void pixel_store(longint base, int slot, int v);
    int pos;
    int idx;
    bit [7:0] d;
    bit [7:0] w;
    for (int b = 0; b < PB; b++) begin
      pos = slot * PB + b;
      idx = int'(base) + ((pos >> 3) ^ 1);
      d = frame_bytes.exists(idx) ? frame_bytes[idx] : 8'h00;
      w = frame_written.exists(idx) ? frame_written[idx] : 8'h00;
      d[7 - (pos & 7)] = 1'((v >> (PB - 1 - b)) & 1);
      w[7 - (pos & 7)] = 1'b1;
      frame_bytes[idx] = d;
      frame_written[idx] = w;
    end
  endfunction

  // expected result of one command; returns 0 if it would read unwritten pixels
  function automatic bit patch_store_result(input pixel_cmd_t it, input bit commit,
                                            output pixel_result_t res);
    longint base;
    longint nb;
    bit ok;
    bit all_ok;
    bit safe;
    int sum;
    int cnt;
    int nx;
    int ny;
    int v;
    int slot;
    safe = 1;
    res.pix = 0;
    res.st = ST_DONE;
    base = group_addr(it.x, it.y);
    ok = base + GB <= FB;
    slot = it.x % GP;
    case (it.cmd)
      CMD_WRITE: begin
        if (ok) begin
          if (commit) pixel_store(base, slot, it.value & PMASK);
        end else res.st = ST_RANGE;
      end
      CMD_READ: begin
        if (ok) begin
          safe = pixel_known(base, slot);
          res.pix = 14'(pixel_load(base, slot));
        end else res.st = ST_RANGE;
      end
      CMD_PATCH: begin
        if (!(it.x >= 2 && it.x + 2 < cfg_rp && it.y >= 2 && it.y + 2 < cfg_rc)) begin
          res.st = ST_SKIP;
        end else if (cfg_mode == MODE_INTERP || cfg_dng != 0) begin
          sum = 0;
          cnt = 0;
          all_ok = ok;
          for (int k = 0; k < 4; k++) begin
            nx = (k & 1) ? it.x + 2 : it.x - 2;
            ny = (k & 2) ? it.y + 2 : it.y - 2;
            nb = group_addr(nx, ny);
            if (nb + GB <= FB) begin
              if (!pixel_known(nb, nx % GP)) safe = 0;
              v = pixel_load(nb, nx % GP);
              if (v != 0) begin
                sum += v;
                cnt++;
              end
            end else all_ok = 0;
          end
          if (!all_ok) res.st = ST_RANGE;
          else if (cnt == 0) res.st = ST_SKIP;
          else begin
            res.pix = 14'((sum / cnt) & PMASK);
            if (commit) pixel_store(base, slot, int'(res.pix));
          end
        end else if (cfg_mode == MODE_ZERO) begin
          if (ok) begin
            if (commit) pixel_store(base, slot, 0);
          end else res.st = ST_RANGE;
        end else res.st = ST_SKIP;
      end
      default: res.st = ST_SKIP;
    endcase
    if (res.st != ST_DONE) res.pix = 0;
    return safe;
  endfunction

  // result checker
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata[13:0] !== want.pix) begin
          $display("%0t pixel_value mismatch: expected %0d, actual %0d",
                   $time, want.pix, m_axis_tdata[13:0]);
          errors++;
        end
        if (m_axis_tdata[15:14] !== want.st) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, want.st, m_axis_tdata[15:14]);
          errors++;
        end
      end
    end
  end

  // receiver ready, random unless quiet, with a long hold-off on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_item(pixel_cmd_t it);
    pixel_result_t res;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.value, 14'(it.y), 14'(it.x), it.cmd};
    do @(posedge clk); while (!s_axis_tready);
    void'(patch_store_result(it, 1, res));
    results_due.push_back(res);
  endtask

  task automatic send_cmd(logic [1:0] cmd, int x, int y, int value);
    pixel_cmd_t it;
    it.cmd = cmd;
    it.x = x;
    it.y = y;
    it.value = 14'(value);
    send_item(it);
  endtask

  task automatic wait_results;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROW_BYTES:  cfg_rb = value & 16'h7fff;
      REG_ROW_PIXELS: cfg_rp = value & 16'h3fff;
      REG_ROW_COUNT:  cfg_rc = value & 16'h3fff;
      REG_MODE:       cfg_mode = value & 3;
      default:        cfg_dng = value & 1;
    endcase
  endtask

  task automatic set_frame(int rb, int rp, int rc, int mode, int dng);
    wait_results();
    write_reg(REG_ROW_BYTES, rb);
    write_reg(REG_ROW_PIXELS, rp);
    write_reg(REG_ROW_COUNT, rc);
    write_reg(REG_MODE, mode);
    write_reg(REG_DNG, dng);
  endtask

  // mostly in-window traffic, some noise anywhere; unsafe reads and patches become writes
  task automatic send_random(int n, int w, int h);
    pixel_cmd_t it;
    pixel_result_t res;
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      it.value = 14'($urandom_range(16383));
      if (r < 8) begin
        it.cmd = 2'($urandom_range(3));
        it.x = $urandom_range(16383);
        it.y = $urandom_range(16383);
      end else begin
        it.cmd = (r < 40) ? CMD_WRITE : (r < 70) ? CMD_READ : CMD_PATCH;
        it.x = $urandom_range(w - 1);
        it.y = $urandom_range(h - 1);
      end
      if (!patch_store_result(it, 0, res)) it.cmd = CMD_WRITE;
      send_item(it);
    end
  endtask

  task automatic fill_window(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send_cmd(CMD_WRITE, x, y, ($urandom_range(3) == 0) ? 0 : $urandom_range(16383));
  endtask

  task automatic test_directed;
    set_frame(48, 32, 16, MODE_INTERP, 0);
    send_cmd(CMD_WRITE, 2, 2, 100);
    send_cmd(CMD_WRITE, 6, 2, 16383);
    send_cmd(CMD_WRITE, 2, 6, 0);
    send_cmd(CMD_WRITE, 6, 6, 7);
    send_cmd(CMD_READ, 6, 2, 0);
    send_cmd(CMD_PATCH, 4, 4, 0);
    send_cmd(CMD_READ, 4, 4, 0);
    send_cmd(CMD_WRITE, 3, 3, 0);
    send_cmd(CMD_WRITE, 7, 3, 0);
    send_cmd(CMD_WRITE, 3, 7, 0);
    send_cmd(CMD_WRITE, 7, 7, 0);
    send_cmd(CMD_PATCH, 5, 5, 0);
    send_cmd(CMD_PATCH, 1, 5, 0);
    send_cmd(CMD_PATCH, 30, 5, 0);
    send_cmd(CMD_PATCH, 5, 1, 0);
    send_cmd(CMD_PATCH, 5, 14, 0);
    send_cmd(CMD_WRITE, 31, 15, 16383);
    send_cmd(CMD_READ, 31, 15, 0);
    send_cmd(CMD_WRITE, 16383, 0, 2730);
    send_cmd(CMD_READ, 16383, 0, 0);
    send_cmd(CMD_WRITE, 0, 16383, 1);
    send_cmd(CMD_READ, 16383, 16383, 0);
    send_cmd(2'd3, 4, 4, 5);
  endtask

  task automatic test_interpolate;
    fill_window(12, 10);
    send_random(140, 12, 10);
  endtask

  task automatic test_zero_mode;
    set_frame(48, 12, 10, MODE_ZERO, 0);
    send_random(80, 12, 10);
    fill_window(12, 3);
  endtask

  task automatic test_dng_forced;
    set_frame(40, 20, 9, 0, 1);
    quiet = 1;
    send_random(100, 20, 9);
    quiet = 0;
  endtask

  task automatic test_mode_off;
    set_frame(48, 4, 4, 0, 0);
    send_random(30, 12, 10);
    set_frame(48, 12, 10, 3, 0);
    send_random(30, 12, 10);
  endtask

  task automatic test_extremes;
    set_frame(32767, 16383, 16383, MODE_INTERP, 0);
    fill_window(8, 9);
    send_random(80, 8, 10);
    set_frame(0, 0, 0, MODE_ZERO, 1);
    send_random(70, 64, 16384);
  endtask

  task automatic test_backpressure;
    set_frame(48, 32, 16, MODE_INTERP, 0);
    stall_left = 400;
    quiet = 1;
    send_random(40, 12, 10);
    quiet = 0;
    wait_results();
    send_random(60, 12, 10);
  endtask

  initial begin
    clk = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    quiet = 0;
    cfg_rb = 0;
    cfg_rp = 0;
    cfg_rc = 0;
    cfg_mode = 0;
    cfg_dng = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_interpolate();
    test_zero_mode();
    test_dng_forced();
    test_mode_off();
    test_extremes();
    test_backpressure();
    wait_results();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/prbpp_pkg.sv
sv/packed_raw_pixel_store_bad_pixel_patch_unit.sv
tb/packed_raw_pixel_store_bad_pixel_patch_unit_tb.sv
